[rtl/core/lssd_pkg.sv]
// Package for the lidar side selector with debounce.
// Widths, limits and configuration register indexes; no dependencies.
`default_nettype none

package lssd_pkg;

    localparam int MAX_BEAMS = 1024;

    localparam int RANGE_W = 16;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int SUM_W   = 26;
    localparam int RUN_W   = 4;
    localparam int PROD_W  = SUM_W + CNT_W;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_RIGHT_FIRST = 3'd0,
        CFG_RIGHT_COUNT = 3'd1,
        CFG_LEFT_FIRST  = 3'd2,
        CFG_LEFT_COUNT  = 3'd3,
        CFG_RANGE_MIN   = 3'd4,
        CFG_RANGE_MAX   = 3'd5,
        CFG_THRESHOLD   = 3'd6
    } t_cfg_idx;

endpackage

`default_nettype wire

[rtl/core/lidar_side_select_debounce.sv]
// Lidar side selector with debounce: window accumulation, decision, run counter.
// Depends on lssd_pkg.
//
// One beam word is taken per clock cycle, with no gaps, for as long as the
// result side keeps up. Each beam whose index falls in the right or left
// window and whose range lies strictly between the range limits is added to
// that window's sum and count. The word flagged last_beam closes the scan:
// its result passes from the input register through the accumulate/snapshot
// stage and the cross-multiply stage to the decision register, which holds
// the result word. Accumulators clear as the scan closes, so the next scan's
// first beam may follow directly. Only a stalled result register holds back
// the pipeline. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module lidar_side_select_debounce (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [lssd_pkg::CFG_A_W-1:0]        i_cfg_idx,
    input  wire [lssd_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire [lssd_pkg::RANGE_W-1:0]        i_range_mm,
    input  wire [lssd_pkg::IDX_W-1:0]          i_beam_index,
    input  wire                                i_last_beam,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_decided_side,
    output logic                               o_follow_side,
    output logic                               o_mode_changed,
    output logic [lssd_pkg::RUN_W-1:0]         o_run_length
);
    import lssd_pkg::*;

    localparam int BIDX_W = $clog2(MAX_BEAMS + 1) + 1;

    // configuration
    logic [IDX_W-1:0]   r_cfg_rfirst, r_cfg_lfirst;
    logic [CNT_W-1:0]   r_cfg_rcount, r_cfg_lcount;
    logic [RANGE_W-1:0] r_cfg_min, r_cfg_max;
    logic [RUN_W-1:0]   r_cfg_thr;

    // stage A: input register
    logic               r_a_v, r_a_hit_r, r_a_hit_l, r_a_last;
    logic [RANGE_W-1:0] r_a_range;

    // accumulators
    logic [SUM_W-1:0]   r_rsum, r_lsum;
    logic [CNT_W-1:0]   r_rcnt, r_lcnt;

    // stage S: closed scan snapshot
    logic               r_s_v;
    logic [SUM_W-1:0]   r_s_rsum, r_s_lsum;
    logic [CNT_W-1:0]   r_s_rcnt, r_s_lcnt;

    // stage M: products
    logic               r_m_v, r_m_nonempty;
    logic [PROD_W-1:0]  r_m_lprod, r_m_rprod;

    // decision state
    logic               r_run_side, r_follow, r_side_chosen;
    logic [RUN_W-1:0]   r_run_cnt;
    logic               n_run_side, n_follow, n_side_chosen, n_changed;
    logic [RUN_W-1:0]   n_run_cnt;

    // result register
    logic               r_o_v, r_o_dec, r_o_follow, r_o_changed;
    logic [RUN_W-1:0]   r_o_run;

    logic o_free, m_free, s_free, a_move, a_free, s_move, m_move, in_fire;
    logic idx_ok, range_ok, hit_r, hit_l, dec;
    logic [SUM_W:0]   acc_rsum_w, acc_lsum_w;
    logic [SUM_W-1:0] acc_rsum, acc_lsum;
    logic [CNT_W-1:0] acc_rcnt, acc_lcnt;
    logic [IDX_W+1:0] idx_x, rend, lend;

    // flow control
    assign o_free  = !r_o_v || i_out_ready;
    assign m_move  = r_m_v && o_free;
    assign m_free  = !r_m_v || o_free;
    assign s_move  = r_s_v && m_free;
    assign s_free  = !r_s_v || m_free;
    assign a_move  = r_a_v && (!r_a_last || s_free);
    assign a_free  = !r_a_v || a_move;
    assign in_fire = i_in_valid && a_free;
    assign o_in_ready = a_free;

    // window and range test on the incoming word
    assign idx_x    = {2'b00, i_beam_index};
    assign rend     = {2'b00, r_cfg_rfirst} + {1'b0, r_cfg_rcount};
    assign lend     = {2'b00, r_cfg_lfirst} + {1'b0, r_cfg_lcount};
    assign idx_ok   = BIDX_W'(i_beam_index) < BIDX_W'(MAX_BEAMS);
    assign range_ok = (i_range_mm > r_cfg_min) && (i_range_mm < r_cfg_max);
    assign hit_r    = range_ok && idx_ok && (i_beam_index >= r_cfg_rfirst) && (idx_x < rend);
    assign hit_l    = range_ok && idx_ok && (i_beam_index >= r_cfg_lfirst) && (idx_x < lend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rfirst <= '0;
            r_cfg_rcount <= '0;
            r_cfg_lfirst <= '0;
            r_cfg_lcount <= '0;
            r_cfg_min    <= '0;
            r_cfg_max    <= '1;
            r_cfg_thr    <= RUN_MAX;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RIGHT_FIRST: r_cfg_rfirst <= i_cfg_data[IDX_W-1:0];
                CFG_RIGHT_COUNT: r_cfg_rcount <= i_cfg_data[CNT_W-1:0];
                CFG_LEFT_FIRST:  r_cfg_lfirst <= i_cfg_data[IDX_W-1:0];
                CFG_LEFT_COUNT:  r_cfg_lcount <= i_cfg_data[CNT_W-1:0];
                CFG_RANGE_MIN:   r_cfg_min    <= i_cfg_data[RANGE_W-1:0];
                CFG_RANGE_MAX:   r_cfg_max    <= i_cfg_data[RANGE_W-1:0];
                CFG_THRESHOLD:   r_cfg_thr    <= i_cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_free) begin
            r_a_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_range <= i_range_mm;
            r_a_hit_r <= hit_r;
            r_a_hit_l <= hit_l;
            r_a_last  <= i_last_beam;
        end
    end

    // saturating accumulate
    assign acc_rsum_w = {1'b0, r_rsum} + (SUM_W+1)'(r_a_range);
    assign acc_lsum_w = {1'b0, r_lsum} + (SUM_W+1)'(r_a_range);

    always_comb begin
        acc_rsum = r_rsum;
        acc_rcnt = r_rcnt;
        acc_lsum = r_lsum;
        acc_lcnt = r_lcnt;
        if (r_a_hit_r) begin
            acc_rsum = acc_rsum_w[SUM_W] ? SUM_MAX : acc_rsum_w[SUM_W-1:0];
            acc_rcnt = (r_rcnt == CNT_MAX) ? r_rcnt : r_rcnt + 1'b1;
        end
        if (r_a_hit_l) begin
            acc_lsum = acc_lsum_w[SUM_W] ? SUM_MAX : acc_lsum_w[SUM_W-1:0];
            acc_lcnt = (r_lcnt == CNT_MAX) ? r_lcnt : r_lcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsum <= '0;
            r_lsum <= '0;
            r_rcnt <= '0;
            r_lcnt <= '0;
        end else if (a_move) begin
            if (r_a_last) begin
                r_rsum <= '0;
                r_lsum <= '0;
                r_rcnt <= '0;
                r_lcnt <= '0;
            end else begin
                r_rsum <= acc_rsum;
                r_lsum <= acc_lsum;
                r_rcnt <= acc_rcnt;
                r_lcnt <= acc_lcnt;
            end
        end
    end

    // stage S
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (s_free) begin
            r_s_v <= a_move && r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move && r_a_last) begin
            r_s_rsum <= acc_rsum;
            r_s_lsum <= acc_lsum;
            r_s_rcnt <= acc_rcnt;
            r_s_lcnt <= acc_lcnt;
        end
    end

    // stage M: cross-multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (m_free) begin
            r_m_v <= s_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_move) begin
            r_m_lprod    <= PROD_W'(r_s_lsum) * PROD_W'(r_s_rcnt);
            r_m_rprod    <= PROD_W'(r_s_rsum) * PROD_W'(r_s_lcnt);
            r_m_nonempty <= (r_s_rcnt != '0) && (r_s_lcnt != '0);
        end
    end

    // decision and debounce
    assign dec = r_m_nonempty && (r_m_lprod > r_m_rprod);

    always_comb begin
        n_run_side    = r_run_side;
        n_run_cnt     = r_run_cnt;
        n_follow      = r_follow;
        n_side_chosen = r_side_chosen;
        n_changed     = 1'b0;
        if (!r_side_chosen) begin
            n_run_side    = dec;
            n_run_cnt     = RUN_W'(1);
            n_follow      = dec;
            n_side_chosen = 1'b1;
            n_changed     = 1'b1;
        end else begin
            if (r_run_cnt == '0 || r_run_side != dec) begin
                n_run_side = dec;
                n_run_cnt  = RUN_W'(1);
            end else if (r_run_cnt < RUN_MAX) begin
                n_run_cnt = r_run_cnt + 1'b1;
            end
            if (n_run_cnt >= r_cfg_thr && r_follow != dec) begin
                n_follow  = dec;
                n_changed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_side    <= 1'b0;
            r_run_cnt     <= '0;
            r_follow      <= 1'b0;
            r_side_chosen <= 1'b0;
            r_o_v         <= 1'b0;
        end else begin
            if (o_free) begin
                r_o_v <= m_move;
            end
            if (m_move) begin
                r_run_side    <= n_run_side;
                r_run_cnt     <= n_run_cnt;
                r_follow      <= n_follow;
                r_side_chosen <= n_side_chosen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_move) begin
            r_o_dec     <= dec;
            r_o_follow  <= n_follow;
            r_o_changed <= n_changed;
            r_o_run     <= n_run_cnt;
        end
    end

    assign o_out_valid    = r_o_v;
    assign o_decided_side = r_o_dec;
    assign o_follow_side  = r_o_follow;
    assign o_mode_changed = r_o_changed;
    assign o_run_length   = r_o_run;

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side_chosen |-> r_run_cnt != '0)
        else $error("run counter zero after side chosen");

    a_out_after_choice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> r_side_chosen)
        else $error("result without a chosen side");

    a_change_follows_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_changed |-> r_o_follow == r_o_dec)
        else $error("followed side changed away from decision");

    a_snapshot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v && !m_free |=> r_s_v && $stable(r_s_rsum) && $stable(r_s_lcnt))
        else $error("snapshot lost while stalled");

endmodule

`default_nettype wire
